[rtl/core/nti_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nti_pkg
// Shared types, widths and the thermistor curve for the NTC table
// interpolator.
// ----------------------------------------------------------------------------
package nti_pkg;

    // Number of (code, temperature) pairs held in the curve ROM.
    localparam int STORED_ENTRIES     = 33;
    localparam int DEF_TABLE_ENTRIES  = 33;
    localparam int IDX_W              = $clog2(STORED_ENTRIES);

    // Field widths.
    localparam int KIND_W  = 1;
    localparam int VALUE_W = 32;
    localparam int CODE_W  = 12;
    localparam int RES_W   = 19;
    localparam int THR_W   = 8;
    localparam int THR_LSB = 4;

    // Internal arithmetic: differences of keys and values need one bit more
    // than the widest table value, products need twice that.
    localparam int VAL_W = RES_W + 1;
    localparam int DVD_W = 2 * VAL_W;

    // Conversion direction.
    localparam logic KIND_CODE_TO_TEMP = 1'b0;
    localparam logic KIND_TEMP_TO_CODE = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0]       code;
        logic signed [RES_W-1:0] temp;
    } t_entry;

    function automatic t_entry mk_entry(input logic [CODE_W-1:0] c,
                                        input logic signed [RES_W-1:0] t);
        t_entry e;
        e.code = c;
        e.temp = t;
        return e;
    endfunction

    // Thermistor curve: code falls and temperature rises with the index.
    function automatic t_entry curve_entry(input logic [IDX_W-1:0] idx);
        t_entry e;
        case (idx)
            6'd0:    e = mk_entry(12'hF8D, -19'sd26428);
            6'd1:    e = mk_entry(12'hF6A, -19'sd21922);
            6'd2:    e = mk_entry(12'hF29, -19'sd15958);
            6'd3:    e = mk_entry(12'hEE4, -19'sd11060);
            6'd4:    e = mk_entry(12'hE9D, -19'sd6890);
            6'd5:    e = mk_entry(12'hE3F, -19'sd2264);
            6'd6:    e = mk_entry(12'hDBF, 19'sd2961);
            6'd7:    e = mk_entry(12'hD33, 19'sd7818);
            6'd8:    e = mk_entry(12'hC97, 19'sd12525);
            6'd9:    e = mk_entry(12'hBF5, 19'sd16945);
            6'd10:   e = mk_entry(12'hB3A, 19'sd21623);
            6'd11:   e = mk_entry(12'hA42, 19'sd27431);
            6'd12:   e = mk_entry(12'h7F1, 19'sd40631);
            6'd13:   e = mk_entry(12'h734, 19'sd44960);
            6'd14:   e = mk_entry(12'h66B, 19'sd49757);
            6'd15:   e = mk_entry(12'h5A3, 19'sd54854);
            6'd16:   e = mk_entry(12'h4EE, 19'sd59898);
            6'd17:   e = mk_entry(12'h446, 19'sd65076);
            6'd18:   e = mk_entry(12'h43A, 19'sd65779);
            6'd19:   e = mk_entry(12'h430, 19'sd65856);
            6'd20:   e = mk_entry(12'h3C3, 19'sd69654);
            6'd21:   e = mk_entry(12'h3BD, 19'sd69873);
            6'd22:   e = mk_entry(12'h33B, 19'sd74910);
            6'd23:   e = mk_entry(12'h2BB, 19'sd80691);
            6'd24:   e = mk_entry(12'h259, 19'sd85844);
            6'd25:   e = mk_entry(12'h206, 19'sd90915);
            6'd26:   e = mk_entry(12'h1CE, 19'sd94873);
            6'd27:   e = mk_entry(12'h191, 19'sd99720);
            6'd28:   e = mk_entry(12'h160, 19'sd104216);
            6'd29:   e = mk_entry(12'h12E, 19'sd109531);
            6'd30:   e = mk_entry(12'h0F9, 19'sd116445);
            6'd31:   e = mk_entry(12'h0D7, 19'sd121600);
            6'd32:   e = mk_entry(12'h09F, 19'sd131839);
            default: e = mk_entry(12'h09F, 19'sd131839);
        endcase
        return e;
    endfunction

endpackage

[rtl/core/nti_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nti_rom
// Synchronous curve ROM: the read is registered, so an entry appears in the cycle after its address.
// ----------------------------------------------------------------------------
module nti_rom (
    input  logic                       i_clk,
    input  logic [nti_pkg::IDX_W-1:0]  i_addr,
    output nti_pkg::t_entry            o_data
);
    import nti_pkg::*;

    t_entry r_data;

    // Registered read of the entry at the presented address.
    always_ff @(posedge i_clk) begin
        r_data <= curve_entry(i_addr);
    end

    assign o_data = r_data;

endmodule

[rtl/core/nti_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nti_div
// Signed restoring divider, two quotient bits per cycle. The quotient and
// remainder truncate toward zero and hold until the next start.
// ----------------------------------------------------------------------------
module nti_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [nti_pkg::DVD_W-1:0]  i_dividend,
    input  logic signed [nti_pkg::VAL_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic signed [nti_pkg::DVD_W-1:0]  o_quotient,
    output logic signed [nti_pkg::VAL_W-1:0]  o_remainder
);
    import nti_pkg::*;

    localparam int STEPS = DVD_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [VAL_W-1:0] r_dvs;
    logic             r_neg_q;
    logic             r_neg_r;

    logic [VAL_W:0]   t1;
    logic [VAL_W:0]   t2;
    logic             ge1;
    logic             ge2;
    logic [VAL_W-1:0] rem1;
    logic [VAL_W-1:0] rem2;
    logic [DVD_W-1:0] quo1;
    logic [DVD_W-1:0] quo2;
    logic [DVD_W-1:0] mag_a;
    logic [VAL_W-1:0] mag_b;

    // Operand magnitudes.
    assign mag_a = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : i_dividend;
    assign mag_b = i_divisor[VAL_W-1]  ? VAL_W'(-i_divisor)  : i_divisor;

    // Two restoring steps per cycle; the dividend shifts out of the top of
    // the quotient register while quotient bits shift in at the bottom.
    always_comb begin
        t1   = {r_rem, r_quo[DVD_W-1]};
        ge1  = (t1 >= {1'b0, r_dvs});
        rem1 = ge1 ? VAL_W'(t1 - {1'b0, r_dvs}) : t1[VAL_W-1:0];
        quo1 = {r_quo[DVD_W-2:0], ge1};
        t2   = {rem1, quo1[DVD_W-1]};
        ge2  = (t2 >= {1'b0, r_dvs});
        rem2 = ge2 ? VAL_W'(t2 - {1'b0, r_dvs}) : t2[VAL_W-1:0];
        quo2 = {quo1[DVD_W-2:0], ge2};
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= mag_a;
            r_dvs   <= mag_b;
            r_neg_q <= i_dividend[DVD_W-1] ^ i_divisor[VAL_W-1];
            r_neg_r <= i_dividend[DVD_W-1];
        end else if (r_busy) begin
            r_rem <= rem2;
            r_quo <= quo2;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_neg_q ? -$signed(r_quo) : $signed(r_quo);
    assign o_remainder = r_neg_r ? -$signed(r_rem) : $signed(r_rem);

endmodule

[rtl/core/ntc_table_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_table_interpolator
// Converts a thermistor code to millidegrees or back through a piecewise
// linear curve held in a synchronous ROM.
// ----------------------------------------------------------------------------
// The block takes one conversion at a time: start is accepted while busy is
// low. The result is registered on o_result and o_threshold_code and held
// there, and o_done is high for exactly one cycle. The receiver cannot stall,
// so o_done must be sampled in that cycle; busy falls in the same cycle, so
// the next start can be given right then. An input at or beyond either end
// of the curve returns the end entry after its end check, an exact key match
// after the end checks and the search probes. An input between keys goes
// through the ROM lookups for the end checks, the binary search probes (each
// one ROM read), the fetch of the segment ends, a divider pass, the two
// multiply steps, a second divider pass and the result. The divider
// retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ntc_table_interpolator #(
    parameter int TABLE_ENTRIES = nti_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [nti_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [nti_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_done,
    output logic signed [nti_pkg::RES_W-1:0]    o_result,
    output logic [nti_pkg::THR_W-1:0]           o_threshold_code
);
    import nti_pkg::*;

    // Entries in use, limited to the stored curve and at least two.
    localparam int EFF_ENTRIES = (TABLE_ENTRIES > STORED_ENTRIES) ? STORED_ENTRIES :
                                 ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
    localparam int LW = IDX_W + 1;
    localparam logic [LW-1:0] LAST_IDX = LW'(EFF_ENTRIES - 1);
    localparam logic [LW-1:0] MID0_IDX = LW'((EFF_ENTRIES - 1) / 2);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHK0   = 4'd1;
    localparam logic [3:0] S_CHKL   = 4'd2;
    localparam logic [3:0] S_PROBE  = 4'd3;
    localparam logic [3:0] S_FETCHA = 4'd4;
    localparam logic [3:0] S_FETCHB = 4'd5;
    localparam logic [3:0] S_DIV1   = 4'd6;
    localparam logic [3:0] S_MULQ   = 4'd7;
    localparam logic [3:0] S_MULR   = 4'd8;
    localparam logic [3:0] S_DIV2   = 4'd9;

    logic [3:0]                r_state, n_state;
    logic                      r_kind, n_kind;
    logic signed [VALUE_W-1:0] r_x, n_x;
    logic [LW-1:0]             r_lo, n_lo;
    logic [LW-1:0]             r_hi, n_hi;
    logic [LW-1:0]             r_mid, n_mid;
    logic signed [VAL_W-1:0]   r_key_a, n_key_a;
    logic signed [VAL_W-1:0]   r_val_a, n_val_a;
    logic signed [VAL_W-1:0]   r_base, n_base;
    logic signed [VAL_W-1:0]   r_d, n_d;
    logic signed [VAL_W-1:0]   r_n, n_n;
    logic signed [DVD_W-1:0]   r_qn, n_qn;
    logic signed [DVD_W-1:0]   r_div_a, n_div_a;
    logic                      r_div_go, n_div_go;
    logic signed [RES_W-1:0]   r_result, n_result;
    logic [THR_W-1:0]          r_thr, n_thr;
    logic                      r_done, n_done;

    logic [IDX_W-1:0]          rom_addr;
    t_entry                    rom_data;
    logic signed [VAL_W-1:0]   key;
    logic signed [VAL_W-1:0]   val;
    logic signed [VALUE_W-1:0] key_x;
    logic                      lt_rank;
    logic                      gt_rank;
    logic [LW-1:0]             lo_t;
    logic [LW-1:0]             hi_t;
    logic [LW-1:0]             lo_c;
    logic [LW:0]               mid_s;
    logic signed [VAL_W-1:0]   d_c;
    logic signed [VAL_W-1:0]   dx_c;
    logic signed [VAL_W-1:0]   mul_a;
    logic signed [DVD_W-1:0]   mul_p;
    logic signed [DVD_W-1:0]   sum;
    logic                      fin_en;
    logic [RES_W-1:0]          fin_val;
    logic                      div_done;
    logic signed [DVD_W-1:0]   div_q;
    logic signed [VAL_W-1:0]   div_r;

    nti_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    nti_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_go),
        .i_dividend  (r_div_a),
        .i_divisor   (r_d),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // Key and paired value of the entry just read, chosen by direction.
    always_comb begin
        if (r_kind == KIND_TEMP_TO_CODE) begin
            key = VAL_W'(rom_data.temp);
            val = $signed({{(VAL_W - CODE_W){1'b0}}, rom_data.code});
        end else begin
            key = $signed({{(VAL_W - CODE_W){1'b0}}, rom_data.code});
            val = VAL_W'(rom_data.temp);
        end
        key_x = VALUE_W'(key);
        // Keys are ranked so that they rise with the index: codes fall.
        lt_rank = (r_kind == KIND_TEMP_TO_CODE) ? (key_x < r_x) : (key_x > r_x);
        gt_rank = (r_kind == KIND_TEMP_TO_CODE) ? (key_x > r_x) : (key_x < r_x);
    end

    // Shared multiplier: quotient times offset, then remainder times offset.
    assign mul_a = (r_state == S_MULQ) ? div_q[VAL_W-1:0] : div_r;
    assign mul_p = DVD_W'(mul_a * r_n);
    assign sum   = DVD_W'(r_base) + r_qn + div_q;
    assign d_c   = r_key_a - key;
    assign dx_c  = r_val_a - val;

    // Sequencer: clamp checks, binary search over the ROM, interpolation.
    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_x      = r_x;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_key_a  = r_key_a;
        n_val_a  = r_val_a;
        n_base   = r_base;
        n_d      = r_d;
        n_n      = r_n;
        n_qn     = r_qn;
        n_div_a  = r_div_a;
        n_div_go = 1'b0;
        n_result = r_result;
        n_thr    = r_thr;
        n_done   = 1'b0;
        rom_addr = '0;
        fin_en   = 1'b0;
        fin_val  = '0;
        lo_t     = r_lo;
        hi_t     = r_hi;
        lo_c     = r_lo;
        mid_s    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_x     = i_value;
                    n_state = S_CHK0;
                end
            end
            S_CHK0: begin
                if (!lt_rank) begin
                    fin_en  = 1'b1;
                    fin_val = val[RES_W-1:0];
                end else begin
                    rom_addr = LAST_IDX[IDX_W-1:0];
                    n_state  = S_CHKL;
                end
            end
            S_CHKL: begin
                if (!gt_rank) begin
                    fin_en  = 1'b1;
                    fin_val = val[RES_W-1:0];
                end else begin
                    n_lo     = '0;
                    n_hi     = LAST_IDX;
                    n_mid    = MID0_IDX;
                    rom_addr = MID0_IDX[IDX_W-1:0];
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                if (lt_rank) begin
                    lo_t = r_mid + 1'b1;
                end else if (gt_rank) begin
                    hi_t = r_mid - 1'b1;
                end else begin
                    fin_en  = 1'b1;
                    fin_val = val[RES_W-1:0];
                end
                if (!fin_en) begin
                    n_lo = lo_t;
                    n_hi = hi_t;
                    if (lo_t <= hi_t) begin
                        mid_s    = {1'b0, lo_t} + {1'b0, hi_t};
                        n_mid    = mid_s[LW:1];
                        rom_addr = mid_s[IDX_W:1];
                    end else begin
                        // Bracket the input between entries lo-1 and lo.
                        if (lo_t < LW'(1)) begin
                            lo_c = LW'(1);
                        end else if (lo_t > LAST_IDX) begin
                            lo_c = LAST_IDX;
                        end else begin
                            lo_c = lo_t;
                        end
                        n_lo     = lo_c;
                        rom_addr = IDX_W'(lo_c - 1'b1);
                        n_state  = S_FETCHA;
                    end
                end
            end
            S_FETCHA: begin
                n_key_a  = key;
                n_val_a  = val;
                rom_addr = r_lo[IDX_W-1:0];
                n_state  = S_FETCHB;
            end
            S_FETCHB: begin
                if (d_c == '0) begin
                    fin_en  = 1'b1;
                    fin_val = val[RES_W-1:0];
                end else begin
                    n_base   = val;
                    n_d      = d_c;
                    n_n      = VAL_W'(r_x - key_x);
                    n_div_a  = DVD_W'(dx_c);
                    n_div_go = 1'b1;
                    n_state  = S_DIV1;
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    n_state = S_MULQ;
                end
            end
            S_MULQ: begin
                n_qn    = mul_p;
                n_state = S_MULR;
            end
            S_MULR: begin
                n_div_a  = mul_p;
                n_div_go = 1'b1;
                n_state  = S_DIV2;
            end
            S_DIV2: begin
                if (div_done) begin
                    fin_en  = 1'b1;
                    fin_val = sum[RES_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Deliver the result and return to idle.
        if (fin_en) begin
            n_result = $signed(fin_val);
            n_thr    = (r_kind == KIND_TEMP_TO_CODE) ? fin_val[THR_LSB +: THR_W] : '0;
            n_done   = 1'b1;
            n_state  = S_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_div_go <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= n_div_go;
            r_done   <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_x      <= n_x;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_key_a  <= n_key_a;
        r_val_a  <= n_val_a;
        r_base   <= n_base;
        r_d      <= n_d;
        r_n      <= n_n;
        r_qn     <= n_qn;
        r_div_a  <= n_div_a;
        r_result <= n_result;
        r_thr    <= n_thr;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_result         = r_result;
    assign o_threshold_code = r_thr;

endmodule
